[design/mat4_vec4_transform_unit_defines.svh]
// ----------------------------------------------------------------------------
// mat4_vec4_transform_unit_defines
// assertion macros shared by the transform unit
// ----------------------------------------------------------------------------
`ifndef MAT4_VEC4_TRANSFORM_UNIT_DEFINES_SVH
`define MAT4_VEC4_TRANSFORM_UNIT_DEFINES_SVH

// overlapping implication, checked outside reset
`define M4V4_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define M4V4_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/m4v4_pkg.sv]
// ----------------------------------------------------------------------------
// m4v4_pkg
// types and constants of the 4x4 matrix by vector transform unit
// ----------------------------------------------------------------------------
`default_nettype none

package m4v4_pkg;

   localparam int DIM      = 4;
   localparam int ENTRY_W  = 32;
   localparam int PROD_W   = 2 * ENTRY_W;
   localparam int PAIR_W   = PROD_W + 1;
   localparam int SUM_W    = PROD_W + 2;
   localparam int LATENCY  = 4;

   // action codes
   localparam logic ACT_LOAD      = 1'b0;
   localparam logic ACT_TRANSFORM = 1'b1;

   // mode codes
   localparam logic MODE_COLUMN = 1'b0;
   localparam logic MODE_ROW    = 1'b1;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef entry_type [DIM-1:0]       vec_type;
   typedef vec_type [DIM-1:0]         mat_type;

   typedef struct packed {
      logic             action;
      logic [3:0]       entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] vec_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               saturated;
   } rsp_type;

   // load request toward the matrix store
   typedef struct packed {
      logic       wr_en;
      logic [3:0] index;
      entry_type  value;
   } load_type;

endpackage

`default_nettype wire

[design/mat4_vec4_transform_unit.sv]
// ----------------------------------------------------------------------------
// mat4_vec4_transform_unit
// pipelined 4x4 matrix by 4-vector transform, signed fixed point
// ----------------------------------------------------------------------------
//
//   channel  | ports                              | flow
//   ---------+------------------------------------+-----------------------------
//   request  | start, busy, req_word              | word taken when start & !busy
//   response | rsp_strobe, rsp_word               | one-cycle strobe, no stall
//   csr      | csr_valid, csr_ready, csr_wdata    | mode written on valid & ready
//
// one word is taken every cycle; busy is never raised
// a transform word gives its result through the register stages of multiply,
// pair add, final add, shift and clip, one register stage each
// a load word updates the matrix at the edge that takes it, so a transform
// taken in the next cycle already sees the new entry; it gives no result
// synchronous reset restores the identity matrix, column mode and an empty
// pipeline; the receiver cannot stall, so the pipeline never holds
// ----------------------------------------------------------------------------
`default_nettype none

module mat4_vec4_transform_unit
   import m4v4_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   // request channel
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_word,
   // response channel
   output logic         rsp_strobe,
   output rsp_type      rsp_word,
   // csr channel
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_wdata
);

`include "mat4_vec4_transform_unit_defines.svh"

   logic               accept;
   logic               mode_ff;
   logic [LATENCY-1:0] valid_ff;
   logic [LATENCY-1:0] valid_in;
   load_type           load;
   mat_type            opnd;
   vec_type            vec;
   vec_type            lane_result;
   logic [DIM-1:0]     lane_sat;

   // the pipeline never stalls, so every start is taken
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COLUMN;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_wdata;
      end
   end

   // load words go straight to the matrix store
   assign load.wr_en = accept && (req_word.action == ACT_LOAD);
   assign load.index = req_word.entry_index;
   assign load.value = req_word.entry_value;

   m4v4_matrix_regs #(
      .FRAC_BITS (FRAC_BITS)
   ) u_matrix (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .mode  (mode_ff),
      .opnd  (opnd)
   );

   assign vec[0] = req_word.vec_x;
   assign vec[1] = req_word.vec_y;
   assign vec[2] = req_word.vec_z;
   assign vec[3] = req_word.vec_w;

   // one lane per output component
   for (genvar i = 0; i < DIM; i++) begin : g_lane
      m4v4_dot_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .vec    (vec),
         .opnd   (opnd[i]),
         .result (lane_result[i]),
         .sat    (lane_sat[i])
      );
   end

   // valid bits follow the lane stages; only transforms carry a valid
   assign valid_in = {valid_ff[LATENCY-2:0], accept && (req_word.action == ACT_TRANSFORM)};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // response word straight from the lane output registers
   assign rsp_strobe         = valid_ff[LATENCY-1];
   assign rsp_word.out_x     = lane_result[0];
   assign rsp_word.out_y     = lane_result[1];
   assign rsp_word.out_z     = lane_result[2];
   assign rsp_word.out_w     = lane_result[3];
   assign rsp_word.saturated = |lane_sat;

   // every transform word yields a strobe after the pipeline latency
   `M4V4_ASSERT_IMPLIES(a_transform_gives_result, clock, reset, accept && (req_word.action == ACT_TRANSFORM), ##LATENCY rsp_strobe, "transform word lost in pipeline")
   // a load word never produces a response
   `M4V4_ASSERT_IMPLIES(a_load_gives_none, clock, reset, accept && (req_word.action == ACT_LOAD), ##LATENCY !rsp_strobe, "load word produced a response")
   // a cycle without a transform taken leaves no strobe behind
   `M4V4_ASSERT_NEXT(a_idle_no_strobe, clock, reset, !(accept && (req_word.action == ACT_TRANSFORM)), ##(LATENCY-1) !rsp_strobe, "strobe without source")

endmodule

`default_nettype wire

[design/m4v4_matrix_regs.sv]
// ----------------------------------------------------------------------------
// m4v4_matrix_regs
// matrix entry registers with identity reset and per-lane operand selection
// ----------------------------------------------------------------------------
`default_nettype none

module m4v4_matrix_regs
   import m4v4_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire load_type load,
   input  wire logic     mode,
   output mat_type       opnd
);

   localparam entry_type ONE = ENTRY_W'(1) << FRAC_BITS;

   mat_type mat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               mat_ff[r][c] <= (r == c) ? ONE : '0;
            end
         end
      end else if (load.wr_en) begin
         mat_ff[load.index[3:2]][load.index[1:0]] <= load.value;
      end
   end

   // lane i, term j: M[i][j] for column vectors, M[j][i] for row vectors
   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            opnd[i][j] = (mode == MODE_ROW) ? mat_ff[j][i] : mat_ff[i][j];
         end
      end
   end

endmodule

`default_nettype wire

[design/m4v4_dot_lane.sv]
// ----------------------------------------------------------------------------
// m4v4_dot_lane
// one output component: four products, two-level adder tree, shift and clip
// ----------------------------------------------------------------------------
`default_nettype none

module m4v4_dot_lane
   import m4v4_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic    clock,
   input  wire vec_type vec,
   input  wire vec_type opnd,
   output entry_type    result,
   output logic         sat
);

   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  shifted;
   entry_type                result_ff;
   entry_type                result_in;
   logic                     sat_ff;
   logic                     sat_in;
   logic                     fits;

   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         prod_in[j] = PROD_W'(vec[j]) * PROD_W'(opnd[j]);
      end
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
      sum_in     = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
   end

   // arithmetic shift rounds toward minus infinity, then clip to 32 bits
   always_comb begin
      shifted = sum_ff >>> FRAC_BITS;
      fits    = (&shifted[SUM_W-1:ENTRY_W-1]) | ~(|shifted[SUM_W-1:ENTRY_W-1]);
      sat_in  = ~fits;
      if (fits) begin
         result_in = shifted[ENTRY_W-1:0];
      end else if (shifted[SUM_W-1]) begin
         result_in = 32'sh8000_0000;
      end else begin
         result_in = 32'sh7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      pair_ff   <= pair_in;
      sum_ff    <= sum_in;
      result_ff <= result_in;
      sat_ff    <= sat_in;
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

`default_nettype wire
